[hdl/hlkc_pkg.sv]
`default_nettype none
package hlkc_pkg;

    typedef enum logic [2:0] {
        OC_MISS     = 3'd0,
        OC_HIT      = 3'd1,
        OC_FILLED   = 3'd2,
        OC_UPDATED  = 3'd3,
        OC_EVICTED  = 3'd4,
        OC_REJECTED = 3'd5
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_EVICT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [63:0] glyph_key;
        logic [31:0] payload_in;
        logic [11:0] width_in;
        logic [11:0] height_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [31:0] payload_out;
        logic [11:0] width_out;
        logic [11:0] height_out;
        logic [7:0]  slot_out;
        logic        released_valid;
        logic [31:0] released_handle;
        logic [31:0] fill_count;
        logic [31:0] evict_count;
    } t_out_item;

    // Entry layout in the table memory
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] payload;
        logic [11:0] width;
        logic [11:0] height;
        logic [31:0] stamp;
    } t_entry;

endpackage
`default_nettype wire

[hdl/hashed_lru_key_cache_core.sv]
// Hashed key cache with LRU eviction. All SLOTS entries live in one single-port
// synchronous RAM; SLOTS must be a power of two, and the home slot is the low
// bits of the key hash. Each item hashes its key in two halves, the first on
// its beat and the second in ST_HASH, then walks the triangular probe sequence,
// reading each slot in ST_READ and checking it in ST_CHECK. An eviction sweeps
// all SLOTS probes, then reads and rewrites the victim in ST_EVICT. A rejected
// insert or a lookup of key zero goes straight from the beat to ST_DONE. One
// item is in flight at a time: the next beat is taken the cycle after the
// result beat is taken. After reset the RAM is cleared one entry per cycle,
// and no beat is taken until every entry is cleared. Results sit in an output
// register and are held while i_out_stall is high.
`default_nettype none
module hashed_lru_key_cache_core
    import hlkc_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    t_entry r_mem [SLOTS];
    t_entry r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    t_entry          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    t_state r_state, n_state;
    t_in_item r_item, n_item;
    logic [63:0] r_h1, n_h1;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_i, n_i;
    logic [AW-1:0] r_old_slot, n_old_slot;
    logic [31:0] r_old_stamp, n_old_stamp;
    logic r_have_old, n_have_old;
    logic [31:0] r_clock, n_clock, r_fill, n_fill, r_evict, n_evict;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;
    logic [AW-1:0] r_clr, n_clr;

    // Hash split in two halves, the first half registered in r_h1
    logic [63:0] h_a, h_b, h_c, h_d, h_e, h_f, h_g;
    always_comb begin
        h_a = (~i_in_data.glyph_key) + (i_in_data.glyph_key << 21);
        h_b = h_a ^ (h_a >> 24);
        h_c = (h_b + (h_b << 3)) + (h_b << 8);
        h_d = r_h1 ^ (r_h1 >> 14);
        h_e = (h_d + (h_d << 2)) + (h_d << 4);
        h_f = h_e ^ (h_e >> 28);
        h_g = h_f + (h_f << 31);
    end

    logic [AW-1:0] home;
    always_comb begin
        home = h_g[AW-1:0];
    end

    // Next probe: pos(i+1) = pos(i) + (i+1) mod SLOTS
    logic [CW-1:0] i_next;
    logic [AW-1:0] pos_next;
    always_comb begin
        i_next   = r_i + CW'(1);
        pos_next = r_pos + AW'(i_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_clock     <= '0;
            r_fill      <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clock     <= n_clock;
            r_fill      <= n_fill;
            r_evict     <= n_evict;
            r_out_valid <= n_out_valid;
        end
        r_item      <= n_item;
        r_h1        <= n_h1;
        r_pos       <= n_pos;
        r_i         <= n_i;
        r_old_slot  <= n_old_slot;
        r_old_stamp <= n_old_stamp;
        r_have_old  <= n_have_old;
        r_out       <= n_out;
    end

    t_entry new_entry;
    logic [31:0] clk_inc;
    always_comb begin
        clk_inc = r_clock + 32'd1;
        new_entry.key     = r_item.glyph_key;
        new_entry.payload = r_item.payload_in;
        new_entry.width   = r_item.width_in;
        new_entry.height  = r_item.height_in;
        new_entry.stamp   = clk_inc;
    end

    logic in_take;
    assign o_in_stall = (r_state != ST_IDLE) || r_out_valid;
    assign in_take = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_h1        = r_h1;
        n_pos       = r_pos;
        n_i         = r_i;
        n_old_slot  = r_old_slot;
        n_old_stamp = r_old_stamp;
        n_have_old  = r_have_old;
        n_clock     = r_clock;
        n_fill      = r_fill;
        n_evict     = r_evict;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_addr    = r_pos;
        mem_wd      = new_entry;

        case (r_state)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                mem_wd   = '0;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    n_item = i_in_data;
                    n_h1   = h_c;
                    n_out  = '0;
                    if (i_in_data.kind && (i_in_data.payload_in == '0 ||
                        i_in_data.width_in == '0 || i_in_data.height_in == '0 ||
                        i_in_data.glyph_key == '0)) begin
                        n_out.outcome = OC_REJECTED;
                        n_state = ST_DONE;
                    end else if (!i_in_data.kind && i_in_data.glyph_key == '0) begin
                        // key zero never matches: reported as a miss without probing
                        n_out.outcome = OC_MISS;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                n_pos      = home;
                n_i        = '0;
                n_have_old = 1'b0;
                n_state    = ST_READ;
            end
            ST_READ: begin
                mem_addr = r_pos;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = ST_READ;
                if (r_rd.key == '0 && !r_item.kind) begin
                    n_out.outcome = OC_MISS;
                    n_state = ST_DONE;
                end else if (r_rd.key == r_item.glyph_key && !r_item.kind) begin
                    mem_we   = 1'b1;
                    mem_wd   = r_rd;
                    mem_wd.stamp = clk_inc;
                    n_clock  = clk_inc;
                    n_out.outcome     = OC_HIT;
                    n_out.payload_out = r_rd.payload;
                    n_out.width_out   = r_rd.width;
                    n_out.height_out  = r_rd.height;
                    n_out.slot_out    = 8'(r_pos);
                    n_state = ST_DONE;
                end else if (r_rd.key == '0 || r_rd.key == r_item.glyph_key) begin
                    mem_we  = 1'b1;
                    n_clock = clk_inc;
                    n_fill  = r_fill + 32'd1;
                    n_out.slot_out = 8'(r_pos);
                    if (r_rd.key == '0) begin
                        n_out.outcome = OC_FILLED;
                    end else begin
                        n_out.outcome = OC_UPDATED;
                        n_out.released_valid  = (r_rd.payload != '0);
                        n_out.released_handle = r_rd.payload;
                    end
                    n_state = ST_DONE;
                end else if (!r_item.kind) begin
                    // lookup: key mismatch, continue
                end else if (!r_have_old || r_rd.stamp < r_old_stamp) begin
                    n_have_old  = 1'b1;
                    n_old_stamp = r_rd.stamp;
                    n_old_slot  = r_pos;
                end
                if (n_state == ST_READ) begin
                    n_i   = i_next;
                    n_pos = pos_next;
                    if (i_next == CW'(SLOTS)) begin
                        if (r_item.kind) begin
                            n_pos   = n_old_slot;
                            n_state = ST_EVICT;
                        end else begin
                            n_out.outcome = OC_MISS;
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_EVICT: begin
                // on entry the victim is read, then it is written
                mem_addr = r_pos;
                if (r_i == CW'(SLOTS)) begin
                    n_i = '0;
                end else begin
                    mem_we  = 1'b1;
                    n_clock = clk_inc;
                    n_evict = r_evict + 32'd1;
                    n_out.outcome         = OC_EVICTED;
                    n_out.slot_out        = 8'(r_pos);
                    n_out.released_valid  = (r_rd.payload != '0);
                    n_out.released_handle = r_rd.payload;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_out.fill_count  = r_fill;
                n_out.evict_count = r_evict;
                n_out_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("beat taken while busy");

    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid) && o_out_data.outcome == OC_EVICTED)
        |-> (o_out_data.evict_count != $past(o_out_data.evict_count, 3)) ||
            (o_out_data.evict_count != '0))
        else $error("eviction without count");

endmodule
`default_nettype wire
